// ===== rtl/lrmf_pkg.sv =====
// Shared constants and control types for the low-pass and running-median filter.
`timescale 1ns / 1ps
`default_nettype none

package lrmf_pkg;

	// Default sizing of the block.
	localparam int MAX_WINDOW_DEF  = 16;
	localparam int SAMPLE_BITS_DEF = 16;

	// Fraction bits of the low-pass state and the gain.
	localparam int FRAC_BITS = 16;

	// Configuration register widths.
	localparam int GAIN_W     = 17;
	localparam int WLEN_W     = 5;
	localparam int CFG_DATA_W = 17;
	localparam int CFG_IDX_W  = 1;

	// Register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_SMOOTHING_GAIN = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LEN     = 1'd1;

	// Register reset values and the unity gain.
	localparam logic [GAIN_W-1:0] GAIN_ONE   = 17'd65536;
	localparam logic [GAIN_W-1:0] GAIN_RESET = 17'd6554;
	localparam logic [WLEN_W-1:0] WLEN_RESET = 5'd11;

	// Control broadcast to every cell of the sorted chain.
	typedef struct packed {
		logic clr;   // restart: drop all held samples
		logic step;  // a sample is inserted this cycle
		logic full;  // the window is full, the oldest cell leaves
		logic rk;    // the leaving sample lies at or below the new one
	} cell_ctrl_t;

	// Control of the low-pass unit.
	typedef struct packed {
		logic clr;    // restart the filter
		logic start;  // a sample is accepted, products are formed
		logic adv;    // stage 1 moves on, the state is written back
	} lp_ctrl_t;

endpackage

`default_nettype wire

// ===== rtl/lrmf_cell.sv =====
// One cell of the sorted sample chain: a held sample, its age and its valid flag.
`timescale 1ns / 1ps
`default_nettype none

module lrmf_cell #(
	parameter int X_W   = lrmf_pkg::SAMPLE_BITS_DEF,
	parameter int AGE_W = 4
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire lrmf_pkg::cell_ctrl_t    ctrl,
	input  wire logic signed [X_W-1:0]   x,
	input  wire logic [AGE_W-1:0]        age_last,
	input  wire logic signed [X_W-1:0]   val_r,
	input  wire logic [AGE_W-1:0]        age_r,
	input  wire logic signed [X_W-1:0]   left_val,
	input  wire logic [AGE_W-1:0]        left_age,
	input  wire logic                    left_valid,
	input  wire logic                    left_below,
	input  wire logic                    left_after,
	input  wire logic signed [X_W-1:0]   right_val,
	input  wire logic [AGE_W-1:0]        right_age,
	input  wire logic                    right_le,
	output logic signed [X_W-1:0]        val,
	output logic [AGE_W-1:0]             age,
	output logic                         valid,
	output logic                         le,
	output logic                         below,
	output logic                         after,
	output logic                         rm
);

	logic signed [X_W-1:0] val_q;
	logic [AGE_W-1:0]      age_q;
	logic                  valid_q;
	logic signed [X_W-1:0] val_nx;
	logic [AGE_W-1:0]      age_nx;
	logic                  valid_nx;

	// Local flags. The chain is ordered by value, and among equal values by
	// falling age, so every held sample has a strict place.
	assign le    = valid_q && (val_q <= x);
	assign rm    = ctrl.full && valid_q && (age_q == age_last);
	assign after = ctrl.full && valid_q &&
		((val_q > val_r) || ((val_q == val_r) && (age_q <= age_r)));
	assign below = ctrl.rk ? right_le : le;

	// New content: stay below the new sample, take the new sample, or sit above it.
	always_comb begin
		if (below) begin
			if (after) begin
				val_nx = right_val;
				age_nx = right_age + AGE_W'(1);
			end else begin
				val_nx = val_q;
				age_nx = age_q + AGE_W'(1);
			end
		end else if (left_below) begin
			val_nx = x;
			age_nx = '0;
		end else if (left_after) begin
			val_nx = val_q;
			age_nx = age_q + AGE_W'(1);
		end else begin
			val_nx = left_val;
			age_nx = left_age + AGE_W'(1);
		end
		valid_nx = valid_q | (!ctrl.full & left_valid);
	end

	// Sample and age registers.
	always_ff @(posedge clk) begin
		if (ctrl.step) begin
			val_q <= val_nx;
			age_q <= age_nx;
		end
	end

	// Valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctrl.clr) begin
			valid_q <= 1'b0;
		end else if (ctrl.step) begin
			valid_q <= valid_nx;
		end
	end

	assign val   = val_q;
	assign age   = age_q;
	assign valid = valid_q;

endmodule

`default_nettype wire

// ===== rtl/lrmf_chain.sv =====
// Row of sorted cells holding the window, with the fill count and the median select.
`timescale 1ns / 1ps
`default_nettype none

module lrmf_chain #(
	parameter int MAX_WINDOW  = lrmf_pkg::MAX_WINDOW_DEF,
	parameter int SAMPLE_BITS = lrmf_pkg::SAMPLE_BITS_DEF
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 clr,
	input  wire logic                                 step,
	input  wire logic signed [SAMPLE_BITS-1:0]        x,
	input  wire logic [$clog2(MAX_WINDOW+1)-1:0]      win,
	output logic signed [SAMPLE_BITS-1:0]             median
);

	localparam int X_W   = SAMPLE_BITS;
	localparam int AGE_W = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
	localparam int CNT_W = $clog2(MAX_WINDOW+1);

	logic [CNT_W-1:0]      count_q;
	logic                  full;
	logic                  rk;
	logic [AGE_W-1:0]      age_last;
	logic signed [X_W-1:0] val_r;
	logic [AGE_W-1:0]      age_r;
	lrmf_pkg::cell_ctrl_t  cctrl;

	logic signed [X_W-1:0] c_val [MAX_WINDOW];
	logic [AGE_W-1:0]      c_age [MAX_WINDOW];
	logic [MAX_WINDOW-1:0] c_valid;
	logic [MAX_WINDOW-1:0] c_le;
	logic [MAX_WINDOW-1:0] c_below;
	logic [MAX_WINDOW-1:0] c_after;
	logic [MAX_WINDOW-1:0] c_rm;

	logic [CNT_W-1:0]      lo_idx;
	logic [CNT_W-1:0]      hi_idx;
	logic signed [X_W-1:0] v_lo;
	logic signed [X_W-1:0] v_hi;
	logic [X_W:0]          msum;

	assign full     = (count_q == win);
	assign age_last = AGE_W'(win - CNT_W'(1));

	// The oldest sample, found by its age, is broadcast back to all cells.
	always_comb begin
		val_r = '0;
		age_r = '0;
		for (int j = 0; j < MAX_WINDOW; j++) begin
			val_r = val_r | (c_val[j] & {X_W{c_rm[j]}});
			age_r = age_r | (c_age[j] & {AGE_W{c_rm[j]}});
		end
	end

	assign rk    = full && (val_r <= x);
	assign cctrl = '{clr: clr, step: step, full: full, rk: rk};

	// Fill count: grows until the window is full.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (clr) begin
			count_q <= '0;
		end else if (step && !full) begin
			count_q <= count_q + CNT_W'(1);
		end
	end

	// The cells, each wired to its two neighbors.
	for (genvar j = 0; j < MAX_WINDOW; j++) begin : g_cell
		logic signed [X_W-1:0] lv;
		logic signed [X_W-1:0] rv;
		logic [AGE_W-1:0]      la;
		logic [AGE_W-1:0]      ra;
		logic                  lvld;
		logic                  lbel;
		logic                  laft;
		logic                  rle;

		if (j == 0) begin : g_first
			assign lv   = c_val[0];
			assign la   = c_age[0];
			assign lvld = 1'b1;
			assign lbel = 1'b1;
			assign laft = 1'b0;
		end else begin : g_inner_l
			assign lv   = c_val[j-1];
			assign la   = c_age[j-1];
			assign lvld = c_valid[j-1];
			assign lbel = c_below[j-1];
			assign laft = c_after[j-1];
		end

		if (j == MAX_WINDOW-1) begin : g_last
			assign rv  = c_val[j];
			assign ra  = c_age[j];
			assign rle = 1'b0;
		end else begin : g_inner_r
			assign rv  = c_val[j+1];
			assign ra  = c_age[j+1];
			assign rle = c_le[j+1];
		end

		lrmf_cell #(
			.X_W   (X_W),
			.AGE_W (AGE_W)
		) u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctrl       (cctrl),
			.x          (x),
			.age_last   (age_last),
			.val_r      (val_r),
			.age_r      (age_r),
			.left_val   (lv),
			.left_age   (la),
			.left_valid (lvld),
			.left_below (lbel),
			.left_after (laft),
			.right_val  (rv),
			.right_age  (ra),
			.right_le   (rle),
			.val        (c_val[j]),
			.age        (c_age[j]),
			.valid      (c_valid[j]),
			.le         (c_le[j]),
			.below      (c_below[j]),
			.after      (c_after[j]),
			.rm         (c_rm[j])
		);
	end

	// Median: the two middle cells, which are the same cell for an odd count.
	assign lo_idx = (count_q - CNT_W'(1)) >> 1;
	assign hi_idx = count_q >> 1;

	always_comb begin
		v_lo = '0;
		v_hi = '0;
		for (int j = 0; j < MAX_WINDOW; j++) begin
			v_lo = v_lo | (c_val[j] & {X_W{CNT_W'(j) == lo_idx}});
			v_hi = v_hi | (c_val[j] & {X_W{CNT_W'(j) == hi_idx}});
		end
	end

	// Floor average of the two middle values.
	assign msum   = {v_lo[X_W-1], v_lo} + {v_hi[X_W-1], v_hi};
	assign median = msum[X_W:1];

endmodule

`default_nettype wire

// ===== rtl/lrmf_lowpass.sv =====
// First-order low-pass in Q16 with a registered multiply stage before the state add.
`timescale 1ns / 1ps
`default_nettype none

module lrmf_lowpass #(
	parameter int SAMPLE_BITS = lrmf_pkg::SAMPLE_BITS_DEF
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire lrmf_pkg::lp_ctrl_t                ctrl,
	input  wire logic [lrmf_pkg::GAIN_W-1:0]       gain,
	input  wire logic signed [SAMPLE_BITS-1:0]     x,
	output logic signed [SAMPLE_BITS-1:0]          y
);

	localparam int FRAC = lrmf_pkg::FRAC_BITS;
	localparam int GW   = lrmf_pkg::GAIN_W;
	localparam int ST_W = SAMPLE_BITS + FRAC;
	localparam int P1_W = SAMPLE_BITS + GW + 1;
	localparam int P2_W = ST_W + GW + 1;

	logic signed [ST_W-1:0] state_q;
	logic                   primed_q;
	logic signed [ST_W-1:0] state_eff;
	logic signed [ST_W-1:0] state_new;
	logic [GW-1:0]          g_sat;
	logic signed [GW:0]     g_s;
	logic signed [GW:0]     rest_s;
	logic signed [P1_W-1:0] p1_s1;
	logic signed [P2_W-1:0] p2_s1;
	logic signed [P2_W-1:0] p1_ext;
	logic signed [P2_W-1:0] p2_shr;
	logic signed [P2_W-1:0] sum;

	// Gain limited to one; the remainder weights the old state.
	assign g_sat  = (gain > lrmf_pkg::GAIN_ONE) ? lrmf_pkg::GAIN_ONE : gain;
	assign g_s    = $signed({1'b0, g_sat});
	assign rest_s = $signed({1'b0, lrmf_pkg::GAIN_ONE - g_sat});

	// The first sample after a restart stands in for the state.
	assign state_eff = primed_q ? state_q : $signed({x, {FRAC{1'b0}}});

	// Stage 1: both products.
	always_ff @(posedge clk) begin
		if (ctrl.start) begin
			p1_s1 <= g_s * x;
			p2_s1 <= rest_s * state_eff;
		end
	end

	// Stage 2: g*x plus the floored weighted state.
	assign p1_ext    = P2_W'(p1_s1);
	assign p2_shr    = p2_s1 >>> FRAC;
	assign sum       = p1_ext + p2_shr;
	assign state_new = sum[ST_W-1:0];
	assign y         = state_new[ST_W-1:FRAC];

	// Filter state and primed flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= '0;
			primed_q <= 1'b0;
		end else if (ctrl.clr) begin
			state_q  <= '0;
			primed_q <= 1'b0;
		end else begin
			if (ctrl.start) begin
				primed_q <= 1'b1;
			end
			if (ctrl.adv) begin
				state_q <= state_new;
			end
		end
	end

endmodule

`default_nettype wire

// ===== rtl/lowpass_and_running_median_filter_top.sv =====
// Top level of the low-pass and running-median filter.
//
//   Channel   Signals                           Direction  Moves
//   config    cfg_wr_en, cfg_index, cfg_data    in         one register write
//   input     in_valid, in_ready, sample        in         one sample per transfer
//   output    out_valid, out_ready,             out        one result per transfer
//             lowpass_out, median
//
// A sample is inserted into the sorted cell chain and its low-pass products are
// registered on the cycle of its transfer; once the output register is free,
// stage 1 adds the low-pass state and selects the median into it. The state
// loop (multiply, register, add, write back) sets the rate: no new sample is
// taken while stage 1 holds one. Reset clears the filters and the handshake;
// any register write restarts both filters; a stalled output holds stage 1.
`timescale 1ns / 1ps
`default_nettype none

module lowpass_and_running_median_filter_top #(
	parameter int MAX_WINDOW  = lrmf_pkg::MAX_WINDOW_DEF,
	parameter int SAMPLE_BITS = lrmf_pkg::SAMPLE_BITS_DEF
) (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire logic                                  cfg_wr_en,
	input  wire logic [lrmf_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  wire logic [lrmf_pkg::CFG_DATA_W-1:0]       cfg_data,
	input  wire logic                                  in_valid,
	output logic                                       in_ready,
	input  wire logic signed [SAMPLE_BITS-1:0]         sample,
	output logic                                       out_valid,
	input  wire logic                                  out_ready,
	output logic signed [SAMPLE_BITS-1:0]              lowpass_out,
	output logic signed [SAMPLE_BITS-1:0]              median
);

	localparam int CNT_W = $clog2(MAX_WINDOW+1);

	logic [lrmf_pkg::GAIN_W-1:0] gain_q;
	logic [lrmf_pkg::WLEN_W-1:0] win_len_q;
	logic [CNT_W-1:0]            win_eff;
	logic                        restart;
	logic                        accept;
	logic                        adv;
	logic                        valid_s1;
	logic                        out_valid_q;
	logic signed [SAMPLE_BITS-1:0] lowpass_out_q;
	logic signed [SAMPLE_BITS-1:0] median_q;
	logic signed [SAMPLE_BITS-1:0] lp_y;
	logic signed [SAMPLE_BITS-1:0] med;
	lrmf_pkg::lp_ctrl_t          lp_ctrl;

	// Configuration registers; any write restarts the filters.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_q    <= lrmf_pkg::GAIN_RESET;
			win_len_q <= lrmf_pkg::WLEN_RESET;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				lrmf_pkg::REG_SMOOTHING_GAIN: begin
					gain_q <= cfg_data[lrmf_pkg::GAIN_W-1:0];
				end
				lrmf_pkg::REG_WINDOW_LEN: begin
					win_len_q <= cfg_data[lrmf_pkg::WLEN_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	assign restart = cfg_wr_en &&
		((cfg_index == lrmf_pkg::REG_SMOOTHING_GAIN) || (cfg_index == lrmf_pkg::REG_WINDOW_LEN));

	// Window length held to the range of the chain.
	always_comb begin
		if (win_len_q == '0) begin
			win_eff = CNT_W'(1);
		end else if (32'(win_len_q) > 32'(MAX_WINDOW)) begin
			win_eff = CNT_W'(MAX_WINDOW);
		end else begin
			win_eff = CNT_W'(win_len_q);
		end
	end

	// Handshake: one sample in stage 1 at a time, output register behind it.
	assign in_ready = !valid_s1;
	assign accept   = in_valid && in_ready;
	assign adv      = valid_s1 && (!out_valid_q || out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				valid_s1 <= 1'b1;
			end else if (adv) begin
				valid_s1 <= 1'b0;
			end
			if (adv) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Output payload register.
	always_ff @(posedge clk) begin
		if (adv) begin
			lowpass_out_q <= lp_y;
			median_q      <= med;
		end
	end

	assign lp_ctrl = '{clr: restart, start: accept, adv: adv};

	lrmf_lowpass #(
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_lowpass (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (lp_ctrl),
		.gain   (gain_q),
		.x      (sample),
		.y      (lp_y)
	);

	lrmf_chain #(
		.MAX_WINDOW  (MAX_WINDOW),
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_chain (
		.clk    (clk),
		.arst_n (arst_n),
		.clr    (restart),
		.step   (accept),
		.x      (sample),
		.win    (win_eff),
		.median (med)
	);

	assign out_valid   = out_valid_q;
	assign lowpass_out = lowpass_out_q;
	assign median      = median_q;

endmodule

`default_nettype wire

// ===== rtl/lrmf_checker.sv =====
// Port-level checks of the filter top level, bound to it.
`timescale 1ns / 1ps
`default_nettype none

module lrmf_checker #(
	parameter int SAMPLE_BITS = lrmf_pkg::SAMPLE_BITS_DEF
) (
	input wire logic                               clk,
	input wire logic                               arst_n,
	input wire logic                               cfg_wr_en,
	input wire logic                               in_valid,
	input wire logic                               in_ready,
	input wire logic signed [SAMPLE_BITS-1:0]      sample,
	input wire logic                               out_valid,
	input wire logic                               out_ready,
	input wire logic signed [SAMPLE_BITS-1:0]      lowpass_out,
	input wire logic signed [SAMPLE_BITS-1:0]      median
);

	// Only one sample is worked on at a time.
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("input taken while a sample is still in stage 1");

	// A stalled result holds its payload.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> (out_valid && $stable(lowpass_out) && $stable(median)))
		else $error("stalled result changed");

	// With the output free, a result passes stage 1 into the output register.
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready && (!out_valid || out_ready)) |=> ##1 out_valid)
		else $error("result did not appear after two cycles");

	// The first sample after a restart passes through both filters unchanged.
	a_restart: assert property (@(posedge clk) disable iff (!arst_n)
		(cfg_wr_en && !out_valid) ##1 (in_valid && in_ready && !out_valid && !cfg_wr_en)
		|=> ##1 (out_valid && (lowpass_out == $past(sample, 2)) &&
			(median == $past(sample, 2))))
		else $error("first result after a restart differs from its sample");

endmodule

bind lowpass_and_running_median_filter_top lrmf_checker #(
	.SAMPLE_BITS (SAMPLE_BITS)
) u_lrmf_checker (.*);

`default_nettype wire

// ===== sim/lowpass_and_running_median_filter_top_test.sv =====
// Self-checking testbench for the low-pass and running-median filter top level.
`timescale 1ns / 1ps

module lowpass_and_running_median_filter_top_test;
	import lrmf_pkg::*;

	localparam int SW   = SAMPLE_BITS_DEF;
	localparam int MAXW = MAX_WINDOW_DEF;

	typedef struct packed {
		logic signed [SW-1:0] lowpass;
		logic signed [SW-1:0] median;
	} filter_result_t;

	// Tracks the filter configuration and state, and holds the results still owed.
	class filter_scoreboard;
		logic [GAIN_W-1:0] gain;
		logic [WLEN_W-1:0] wlen;
		longint            lp_state;
		bit                lp_primed;
		longint            ring [MAXW];
		int                held;
		int                oldest;
		filter_result_t    expected_results [$];
		int                errors;

		function new();
			gain   = GAIN_RESET;
			wlen   = WLEN_RESET;
			errors = 0;
			restart();
		endfunction

		function void restart();
			lp_state  = 0;
			lp_primed = 1'b0;
			held      = 0;
			oldest    = 0;
		endfunction

		// Any write to a known register restarts both filters.
		function void apply_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
			if (idx == REG_SMOOTHING_GAIN) begin
				gain = data[GAIN_W-1:0];
				restart();
			end else if (idx == REG_WINDOW_LEN) begin
				wlen = data[WLEN_W-1:0];
				restart();
			end
		endfunction

		// Works out the low-pass value and window median for one accepted sample.
		function void note_sample(logic signed [SW-1:0] x);
			longint         xs;
			longint         g;
			longint         unity;
			longint         sorted [MAXW];
			longint         t;
			longint         med;
			int             win;
			int             n;
			int             j;
			filter_result_t r;

			xs    = x;
			unity = GAIN_ONE;
			g     = (gain > GAIN_ONE) ? unity : longint'(gain);
			if (wlen == 0)
				win = 1;
			else if (wlen > MAXW)
				win = MAXW;
			else
				win = wlen;

			// First-order low-pass in Q16; the first sample loads the state.
			if (!lp_primed) begin
				lp_state  = xs <<< FRAC_BITS;
				lp_primed = 1'b1;
			end
			lp_state = (g * (xs <<< FRAC_BITS) + (unity - g) * lp_state) >>> FRAC_BITS;

			// Ring of the newest samples.
			if (held < win) begin
				ring[(oldest + held) % win] = xs;
				held++;
			end else begin
				ring[oldest % win] = xs;
				oldest = (oldest + 1) % win;
			end

			// Insertion sort of the held samples, then pick the middle.
			n = held;
			for (int i = 0; i < n; i++) begin
				t = ring[i];
				j = i;
				while (j > 0 && sorted[j-1] > t) begin
					sorted[j] = sorted[j-1];
					j--;
				end
				sorted[j] = t;
			end
			if (n % 2 == 1)
				med = sorted[n/2];
			else
				med = (sorted[n/2-1] + sorted[n/2]) >>> 1;

			r.lowpass = SW'(lp_state >>> FRAC_BITS);
			r.median  = SW'(med);
			expected_results = {expected_results, r};
		endfunction

		// Compares one output transfer with the oldest result owed.
		function void check_result(logic signed [SW-1:0] lp, logic signed [SW-1:0] med);
			filter_result_t r;

			if (expected_results.size() == 0) begin
				$error("unexpected result: lowpass_out %0d, median %0d", lp, med);
				errors++;
				return;
			end
			r = expected_results[0];
			expected_results.delete(0);
			if (lp !== r.lowpass) begin
				$error("lowpass_out mismatch: expected %0d, actual %0d", r.lowpass, lp);
				errors++;
			end
			if (med !== r.median) begin
				$error("median mismatch: expected %0d, actual %0d", r.median, med);
				errors++;
			end
		endfunction
	endclass

	logic                    clk       = 1'b0;
	logic                    arst_n    = 1'b0;
	logic                    cfg_wr_en = 1'b0;
	logic [CFG_IDX_W-1:0]    cfg_index = REG_SMOOTHING_GAIN;
	logic [CFG_DATA_W-1:0]   cfg_data  = '0;
	logic                    in_valid  = 1'b0;
	logic                    in_ready;
	logic signed [SW-1:0]    sample    = '0;
	logic                    out_valid;
	logic                    out_ready = 1'b0;
	logic signed [SW-1:0]    lowpass_out;
	logic signed [SW-1:0]    median;

	int idle_pct  = 0;
	int stall_pct = 0;

	filter_scoreboard sb = new();

	lowpass_and_running_median_filter_top u_top (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.sample      (sample),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.lowpass_out (lowpass_out),
		.median      (median)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Output side: check each transfer, then stall at random for the next edge.
	always @(posedge clk) begin
		if (out_valid && out_ready)
			sb.check_result(lowpass_out, median);
		out_ready <= ($urandom_range(99) >= stall_pct);
	end

	// Offers one sample after a random idle gap and waits for its transfer.
	task automatic send_sample(input logic signed [SW-1:0] x);
		int gap;

		gap = 0;
		while ($urandom_range(99) < idle_pct)
			gap++;
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		sample   <= x;
		do @(posedge clk); while (!in_ready);
		sb.note_sample(x);
	endtask

	// Holds off input until every owed result has come and the pipeline is quiet.
	task automatic drain_results();
		in_valid <= 1'b0;
		while (sb.expected_results.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] data);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		sb.apply_write(idx, data);
		cfg_wr_en <= 1'b0;
		@(posedge clk);
	endtask

	// Picks a new gain and window; the window write carries random upper bits.
	task automatic write_random_config();
		logic [CFG_DATA_W-1:0] gain_data;
		logic [CFG_DATA_W-1:0] wlen_data;

		case ($urandom_range(3))
			0: begin
				gain_data = GAIN_ONE;
			end
			1: begin
				gain_data = CFG_DATA_W'($urandom_range(131071));
			end
			2: begin
				gain_data = CFG_DATA_W'($urandom_range(512));
			end
			default: begin
				gain_data = CFG_DATA_W'($urandom_range(65536));
			end
		endcase
		wlen_data = CFG_DATA_W'($urandom);
		if ($urandom_range(1) == 1)
			wlen_data[WLEN_W-1:0] = WLEN_W'($urandom_range(MAXW, 1));
		if ($urandom_range(1) == 1) begin
			write_register(REG_SMOOTHING_GAIN, gain_data);
			write_register(REG_WINDOW_LEN, wlen_data);
		end else begin
			write_register(REG_WINDOW_LEN, wlen_data);
			write_register(REG_SMOOTHING_GAIN, gain_data);
		end
	endtask

	function automatic logic signed [SW-1:0] random_sample();
		case ($urandom_range(9))
			0: begin
				return ($urandom_range(1) == 1) ? 16'sh7FFF : 16'sh8000;
			end
			1, 2: begin
				return SW'(int'($urandom_range(8)) - 4);
			end
			default: begin
				return SW'($urandom_range(65535));
			end
		endcase
	endfunction

	// Reset, directed items, then four phases of random items, idles and stalls.
	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset configuration with the extremes of the sample.
		send_sample(16'sh7FFF);
		send_sample(16'sh8000);
		send_sample(16'sh0000);
		send_sample(-16'sd1);
		send_sample(16'sd1);
		send_sample(16'sd12345);

		// Rewriting the same window length still restarts; odd negative even-count sum.
		drain_results();
		write_register(REG_WINDOW_LEN, CFG_DATA_W'(WLEN_RESET));
		send_sample(16'sh8000);
		send_sample(-16'sd32767);
		send_sample(16'sh7FFF);
		send_sample(16'sd7);

		// Gain above one saturates; a zero window acts as one.
		drain_results();
		write_register(REG_SMOOTHING_GAIN, 17'h1FFFF);
		write_register(REG_WINDOW_LEN, 17'h1FFE0);
		send_sample(16'sh8000);
		send_sample(16'sh7FFF);
		send_sample(16'sd5);

		// Zero gain holds the first sample; an oversized window acts as the maximum.
		drain_results();
		write_register(REG_SMOOTHING_GAIN, 17'h00000);
		write_register(REG_WINDOW_LEN, 17'd31);
		send_sample(16'sh7FFF);
		send_sample(16'sh8000);
		send_sample(16'sh8000);
		send_sample(16'sd100);
		send_sample(-16'sd1);
		send_sample(16'sh7FFF);

		// Unity gain passes the sample through; window of two averages pairs.
		drain_results();
		write_register(REG_SMOOTHING_GAIN, CFG_DATA_W'(GAIN_ONE));
		write_register(REG_WINDOW_LEN, 17'd2);
		send_sample(16'sh8000);
		send_sample(-16'sd32767);
		send_sample(16'sh7FFF);
		send_sample(16'sd0);

		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin
					idle_pct  = 0;
					stall_pct = 0;
				end
				1: begin
					idle_pct  = 49;
					stall_pct = 0;
				end
				2: begin
					idle_pct  = 0;
					stall_pct = 49;
				end
				default: begin
					idle_pct  = 36;
					stall_pct = 36;
				end
			endcase
			for (int k = 0; k < 212; k++) begin
				if (k % 53 == 0) begin
					drain_results();
					write_random_config();
				end
				// Let the output side empty completely once in the middle of a phase.
				if (ph == 3 && k == 100)
					drain_results();
				send_sample(random_sample());
			end
		end

		drain_results();
		repeat (8) @(posedge clk);
		if (sb.errors == 0 && sb.expected_results.size() == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

	// Hard stop in case the handshake hangs.
	initial begin
		#5_000_000;
		$display("TEST FAILED");
		$finish;
	end

endmodule
